/* rtl/cdw_pkg.sv */
// shared types and constants for the checkpoint deadline watchdog
package cdw_pkg;

  localparam int unsigned OpW       = 2;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned IntervalW = 31;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DefChannels = 16;

  typedef enum logic [OpW-1:0] {
    OpRegister = 2'd0,
    OpReached  = 2'd1,
    OpCheck    = 2'd2
  } cdw_op_e;

  typedef enum logic {
    StIdle,
    StScan
  } cdw_state_e;

  // write strobes from the controller into the channel store
  typedef struct packed {
    logic reg_en;
    logic stamp_en;
  } cdw_wr_t;

endpackage

/* rtl/cdw_chan_store.sv */
// channel store: timeout and stamp memories plus per-channel valid bits
module cdw_chan_store
  import cdw_pkg::*;
#(
  parameter int unsigned CHANNELS = DefChannels,
  parameter int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cdw_wr_t          wr_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [TimeW-1:0] timeout_wd_i,
  input  logic [TimeW-1:0] stamp_wd_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  input  logic [IdxW-1:0]  scan_addr_i,
  output logic [TimeW-1:0] timeout_rd_o,
  output logic [TimeW-1:0] stamp_rd_o,
  output logic             vld_wr_o,
  output logic             vld_scan_o
);

  logic [TimeW-1:0]    timeout_mem [CHANNELS];
  logic [TimeW-1:0]    stamp_mem   [CHANNELS];
  logic [CHANNELS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.reg_en) begin
      timeout_mem[wr_addr_i] <= timeout_wd_i;
    end
    if (wr_i.reg_en || wr_i.stamp_en) begin
      stamp_mem[wr_addr_i] <= stamp_wd_i;
    end
    timeout_rd_o <= timeout_mem[rd_addr_i];
    stamp_rd_o   <= stamp_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.reg_en) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign vld_wr_o   = valid_q[wr_addr_i];
  assign vld_scan_o = valid_q[scan_addr_i];

endmodule

/* rtl/cdw_ctrl.sv */
// command decode, channel scan sequencer and result register
module cdw_ctrl
  import cdw_pkg::*;
#(
  parameter int unsigned CHANNELS = DefChannels,
  parameter int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [OpW-1:0]       opcode_i,
  input  logic [ChanW-1:0]     channel_i,
  input  logic [IntervalW-1:0] interval_ms_i,
  input  logic [TimeW-1:0]     now_i,
  output logic                 done_o,
  output logic                 deadlock_o,
  output logic [ChanW-1:0]     expired_channel_o,
  output cdw_wr_t              wr_o,
  output logic [IdxW-1:0]      wr_addr_o,
  output logic [TimeW-1:0]     timeout_wd_o,
  output logic [TimeW-1:0]     stamp_wd_o,
  output logic [IdxW-1:0]      rd_addr_o,
  output logic [IdxW-1:0]      scan_addr_o,
  input  logic [TimeW-1:0]     timeout_rd_i,
  input  logic [TimeW-1:0]     stamp_rd_i,
  input  logic                 vld_wr_i,
  input  logic                 vld_scan_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  cdw_state_e       state_q, state_d;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic [TimeW-1:0] now_q, now_d;
  logic             done_q, done_d;
  logic             deadlock_q, deadlock_d;
  logic [ChanW-1:0] expired_q, expired_d;

  logic             accept;
  logic             in_range;
  logic             hit;
  logic             last;
  logic [TimeW-1:0] age;

  assign accept   = start_i && (state_q == StIdle);
  assign in_range = 32'(channel_i) < CHANNELS;
  assign age      = now_q - stamp_rd_i;
  assign hit      = vld_scan_i && (stamp_rd_i != '0) && (age > timeout_rd_i);
  assign last     = scan_q == LastIdx;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (opcode_i == OpCheck)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (hit || last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    wr_o         = '0;
    wr_addr_o    = IdxW'(channel_i);
    timeout_wd_o = {interval_ms_i, 1'b0};
    stamp_wd_o   = '0;
    scan_d       = scan_q;
    now_d        = now_q;
    done_d       = 1'b0;
    deadlock_d   = deadlock_q;
    expired_d    = expired_q;
    // channel 0 is prefetched while idle so the scan starts with data ready
    rd_addr_o    = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          done_d     = 1'b1;
          deadlock_d = 1'b0;
          expired_d  = '0;
          case (opcode_i)
            OpRegister: begin
              wr_o.reg_en = in_range;
            end
            OpReached: begin
              wr_o.stamp_en = in_range && vld_wr_i;
              stamp_wd_o    = now_i;
            end
            OpCheck: begin
              done_d = 1'b0;
              scan_d = '0;
              now_d  = now_i;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        rd_addr_o = scan_q + 1'b1;
        scan_d    = scan_q + 1'b1;
        if (hit || last) begin
          done_d     = 1'b1;
          deadlock_d = hit;
          expired_d  = hit ? ChanW'(scan_q) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    now_q      <= now_d;
    deadlock_q <= deadlock_d;
    expired_q  <= expired_d;
  end

  assign busy_o            = state_q != StIdle;
  assign scan_addr_o       = scan_q;
  assign done_o            = done_q;
  assign deadlock_o        = deadlock_q;
  assign expired_channel_o = expired_q;

endmodule

/* rtl/checkpoint_deadline_watchdog_core.sv */
// top level of the checkpoint deadline watchdog
// A command is taken when start_i is high and busy_o is low; its result is
// shown for one cycle on done_o, which the receiver cannot stall. Register
// and reached commands do not raise busy_o: the result appears in the cycle
// after the command and a new command may be given in that same cycle.
// A status check walks the channel memories one channel per cycle and
// holds busy_o until an expired channel is found or the last channel is
// checked, and its result is shown in the same cycle that busy_o falls.
// There is no clearing pass after reset; the valid bits clear at once.
module checkpoint_deadline_watchdog_core
  import cdw_pkg::*;
#(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [OpW-1:0]       opcode_i,
  input  logic [ChanW-1:0]     channel_i,
  input  logic [IntervalW-1:0] interval_ms_i,
  input  logic [TimeW-1:0]     now_i,
  output logic                 done_o,
  output logic                 deadlock_o,
  output logic [ChanW-1:0]     expired_channel_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cdw_wr_t          wr;
  logic [IdxW-1:0]  wr_addr;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  scan_addr;
  logic [TimeW-1:0] timeout_wd;
  logic [TimeW-1:0] stamp_wd;
  logic [TimeW-1:0] timeout_rd;
  logic [TimeW-1:0] stamp_rd;
  logic             vld_wr;
  logic             vld_scan;

  cdw_ctrl #(
    .CHANNELS(CHANNELS),
    .IdxW    (IdxW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .channel_i        (channel_i),
    .interval_ms_i    (interval_ms_i),
    .now_i            (now_i),
    .done_o           (done_o),
    .deadlock_o       (deadlock_o),
    .expired_channel_o(expired_channel_o),
    .wr_o             (wr),
    .wr_addr_o        (wr_addr),
    .timeout_wd_o     (timeout_wd),
    .stamp_wd_o       (stamp_wd),
    .rd_addr_o        (rd_addr),
    .scan_addr_o      (scan_addr),
    .timeout_rd_i     (timeout_rd),
    .stamp_rd_i       (stamp_rd),
    .vld_wr_i         (vld_wr),
    .vld_scan_i       (vld_scan)
  );

  cdw_chan_store #(
    .CHANNELS(CHANNELS),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .timeout_wd_i(timeout_wd),
    .stamp_wd_i  (stamp_wd),
    .rd_addr_i   (rd_addr),
    .scan_addr_i (scan_addr),
    .timeout_rd_o(timeout_rd),
    .stamp_rd_o  (stamp_rd),
    .vld_wr_o    (vld_wr),
    .vld_scan_o  (vld_scan)
  );

endmodule

/* rtl/cdw_checker.sv */
// port-level checks for the watchdog core and their bind
module cdw_checker
  import cdw_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic [OpW-1:0]   opcode_i,
  input logic             done_o,
  input logic             deadlock_o,
  input logic [ChanW-1:0] expired_channel_o
);

  // a result never overlaps a running scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // register, reached and unknown commands answer next cycle with no deadlock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i != OpCheck))
      |=> (done_o && !deadlock_o && (expired_channel_o == '0)))
    else $error("non-check transaction result wrong or late");

  // a check always starts a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OpCheck)) |=> busy_o)
    else $error("check transaction did not start a scan");

  // end of a scan comes with its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !deadlock_o) |-> (expired_channel_o == '0))
    else $error("channel reported without deadlock");

endmodule

bind checkpoint_deadline_watchdog_core cdw_checker u_cdw_checker (.*);

/* verif/checkpoint_deadline_watchdog_checker.sv */
// checker that predicts and compares checkpoint deadline watchdog results
module checkpoint_deadline_watchdog_checker
  import cdw_pkg::*;
#(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [OpW-1:0]       opcode_i,
  input  logic [ChanW-1:0]     channel_i,
  input  logic [IntervalW-1:0] interval_ms_i,
  input  logic [TimeW-1:0]     now_i,
  input  logic                 done_i,
  input  logic                 deadlock_i,
  input  logic [ChanW-1:0]     expired_channel_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o
);

  typedef struct packed {
    logic             deadlock;
    logic [ChanW-1:0] channel;
  } verdict_t;

  logic [TimeW-1:0] timeout_ms [CHANNELS];
  logic [TimeW-1:0] stamp_ms   [CHANNELS];
  logic             armed      [CHANNELS];
  verdict_t         pending_verdicts [$];
  verdict_t         oldest;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatch_count_o++;
  endtask

  // updates the channel table and returns the verdict of one command
  function automatic verdict_t apply_command(input cdw_op_e op, input logic [ChanW-1:0] ch,
                                             input logic [IntervalW-1:0] interval,
                                             input logic [TimeW-1:0] now);
    verdict_t         v;
    logic [TimeW-1:0] elapsed;
    v = '0;
    case (op)
      OpRegister: begin
        if (ch < CHANNELS) begin
          timeout_ms[ch] = {interval, 1'b0};
          stamp_ms[ch]   = '0;
          armed[ch]      = 1'b1;
        end
      end
      OpReached: begin
        if (ch < CHANNELS && armed[ch]) begin
          stamp_ms[ch] = now;
        end
      end
      OpCheck: begin
        for (int i = 0; i < CHANNELS; i++) begin
          // wrapping difference, a zero stamp means never reached
          elapsed = now - stamp_ms[i];
          if (!v.deadlock && armed[i] && stamp_ms[i] != '0 && elapsed > timeout_ms[i]) begin
            v.deadlock = 1'b1;
            v.channel  = ChanW'(i);
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (armed[i]) begin
        timeout_ms[i] = '0;
        stamp_ms[i]   = '0;
        armed[i]      = 1'b0;
      end
      pending_verdicts.delete();
      mismatch_count_o = 0;
      outstanding_o <= 0;
    end else begin
      // a result never belongs to the transaction taken at the same edge
      if (done_i) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          oldest = pending_verdicts.pop_front();
          if (deadlock_i !== oldest.deadlock) begin
            report_mismatch($sformatf("deadlock %b, expected %b", deadlock_i, oldest.deadlock));
          end
          if (expired_channel_i !== oldest.channel) begin
            report_mismatch($sformatf("expired channel %0d, expected %0d",
                                      expired_channel_i, oldest.channel));
          end
        end
      end
      if (start_i && !busy_i) begin
        pending_verdicts.push_back(apply_command(cdw_op_e'(opcode_i), channel_i,
                                                 interval_ms_i, now_i));
      end
      outstanding_o <= pending_verdicts.size();
    end
  end

endmodule

/* verif/checkpoint_deadline_watchdog_core_tb.sv */
// testbench top: command stimulus and verdict for the checkpoint deadline watchdog
module checkpoint_deadline_watchdog_core_tb;
  import cdw_pkg::*;

  localparam int unsigned Channels    = DefChannels;
  localparam int unsigned RandomCmds  = 1630;
  localparam int unsigned QuietTail   = 200;
  localparam int unsigned DrainCycles = Channels + 8;
  // the opcode with no function
  localparam logic [OpW-1:0] OpSpare = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 start_i       = 1'b0;
  logic [OpW-1:0]       opcode_i      = '0;
  logic [ChanW-1:0]     channel_i     = '0;
  logic [IntervalW-1:0] interval_ms_i = '0;
  logic [TimeW-1:0]     now_i         = '0;
  logic                 busy_o;
  logic                 done_o;
  logic                 deadlock_o;
  logic [ChanW-1:0]     expired_channel_o;
  int unsigned          mismatch_count;
  int unsigned          outstanding;
  bit                   gaps_on;

  checkpoint_deadline_watchdog_core #(
    .CHANNELS(Channels)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .opcode_i,
    .channel_i,
    .interval_ms_i,
    .now_i,
    .done_o,
    .deadlock_o,
    .expired_channel_o
  );

  checkpoint_deadline_watchdog_checker #(
    .CHANNELS(Channels)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i            (busy_o),
    .opcode_i,
    .channel_i,
    .interval_ms_i,
    .now_i,
    .done_i            (done_o),
    .deadlock_i        (deadlock_o),
    .expired_channel_i (expired_channel_o),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // holds start high until the transaction is taken
  task automatic send_command(input logic [OpW-1:0] op, input logic [ChanW-1:0] ch,
                              input logic [IntervalW-1:0] interval,
                              input logic [TimeW-1:0] now);
    if (gaps_on && $urandom_range(0, 9) < 3) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    opcode_i      <= op;
    channel_i     <= ch;
    interval_ms_i <= interval;
    now_i         <= now;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    logic [OpW-1:0]       op;
    logic [ChanW-1:0]     ch;
    logic [IntervalW-1:0] interval;
    logic [TimeW-1:0]     wall_ms;
    int unsigned          pick;

    gaps_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, unregistered channel, unused opcode
    send_command(OpCheck, 4'd0, '0, '1);
    send_command(OpReached, 4'd5, '0, 32'd1000);
    send_command(OpSpare, 4'd9, 31'h5555_5555, 32'hAAAA_AAAA);
    // timeout extremes
    send_command(OpRegister, 4'd0, '0, '0);
    send_command(OpRegister, 4'd15, '1, '0);
    send_command(OpRegister, 4'd7, 31'd100, '0);
    // reaching at time zero leaves the channel unreached
    send_command(OpReached, 4'd0, '0, '0);
    send_command(OpCheck, 4'd0, '0, '1);
    // elapsed time wraps past zero, exactly at and one past the timeout
    send_command(OpReached, 4'd7, '0, 32'hFFFF_FFF0);
    send_command(OpCheck, 4'd0, '0, 32'd184);
    send_command(OpCheck, 4'd0, '0, 32'd185);
    // lowest expired channel wins
    send_command(OpReached, 4'd0, '0, 32'd5);
    send_command(OpCheck, 4'd0, '0, 32'd5);
    send_command(OpCheck, 4'd0, '0, 32'd300);
    // repeated register clears the stamps
    send_command(OpRegister, 4'd0, '1, '0);
    send_command(OpRegister, 4'd7, 31'd100, '0);
    send_command(OpCheck, 4'd0, '0, 32'd300);
    // largest timeout against largest elapsed time
    send_command(OpReached, 4'd15, '0, 32'd1);
    send_command(OpCheck, 4'd0, '0, '1);
    send_command(OpCheck, 4'd0, '0, '0);
    send_command(OpSpare, 4'd15, '1, '1);

    // start the clock shortly before it wraps
    wall_ms = 32'd0 - $urandom_range(1000, 40000);
    for (int n = 0; n < RandomCmds; n++) begin
      if (n % 64 == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (n >= RandomCmds - QuietTail) begin
        gaps_on = 1'b0;
      end
      ch = ChanW'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        wall_ms += $urandom_range(0, 40);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          op = OpRegister;
        end else if (pick < 65) begin
          op = OpReached;
        end else if (pick < 95) begin
          op = OpCheck;
        end else begin
          op = OpSpare;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          interval = '0;
        end else if (pick < 6) begin
          interval = IntervalW'($urandom_range(1, 200));
        end else begin
          interval = IntervalW'($urandom_range(1, 2000));
        end
        send_command(op, ch, interval, wall_ms);
      end else begin
        // noise: any opcode, any interval, any time
        send_command(OpW'($urandom), ch, IntervalW'($urandom), $urandom);
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cdw_pkg.sv
rtl/cdw_chan_store.sv
rtl/cdw_ctrl.sv
rtl/checkpoint_deadline_watchdog_core.sv
rtl/cdw_checker.sv
verif/checkpoint_deadline_watchdog_checker.sv
verif/checkpoint_deadline_watchdog_core_tb.sv
